### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks used by the rtl modules that include them, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define LGFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define LGFB_NEVER(label, cond, msg) \
  `LGFB_ASSERT(label, !(cond), msg)

`endif

### hw/rtl/lgfb_pkg.sv
// ----------------------------------------------------------------------------
// lgfb_pkg
// shared constants, codes and controller/datapath types of the frame buffer
// ----------------------------------------------------------------------------
package lgfb_pkg;

  localparam int MAX_PIXELS_DEF  = 1024;
  localparam int MAX_ROWS_DEF    = 16;
  localparam int MAX_COLUMNS_DEF = 64;

  localparam int MODE_W     = 4;
  localparam int PIX_W      = 11;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 6;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int RCNT_W     = 5;
  localparam int CCNT_W     = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;

  localparam logic [PIX_W-1:0]  PIXEL_COUNT_RST  = 11'd1024;
  localparam logic [RCNT_W-1:0] ROW_COUNT_RST    = 5'd16;
  localparam logic [CCNT_W-1:0] COLUMN_COUNT_RST = 7'd64;

  localparam logic [PIX_W-1:0] NO_PIXEL = '1;

  localparam logic [MODE_W-1:0] MODE_WRITE     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_READ      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_FILL      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SHIFT_R   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SHIFT_L   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ROW_COLOR = 4'd5;
  localparam logic [MODE_W-1:0] MODE_COL_COLOR = 4'd6;
  localparam logic [MODE_W-1:0] MODE_COLS_R    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_COLS_L    = 4'd8;
  localparam logic [MODE_W-1:0] MODE_ROWS_D    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_ROWS_U    = 4'd10;
  localparam logic [MODE_W-1:0] MODE_MAP       = 4'd11;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd12;

  typedef enum logic [1:0] {
    KIND_LIN,
    KIND_GRID,
    KIND_MAP,
    KIND_READ
  } kind_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic setup;
    logic rd;
    logic wr;
    logic advance;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic empty;
    logic last;
  } sts_t;

endpackage

### hw/rtl/lgfb_cmd_if.sv
// ----------------------------------------------------------------------------
// lgfb_cmd_if
// command channel: valid/ready handshake with one command word
// ----------------------------------------------------------------------------
interface lgfb_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [lgfb_pkg::MODE_W-1:0]       mode;
  logic [lgfb_pkg::PIX_W-1:0]        pixel;
  logic [lgfb_pkg::ROW_W-1:0]        row;
  logic [lgfb_pkg::COL_W-1:0]        column;
  logic [lgfb_pkg::COLOR_W-1:0]      color;
  logic                              use_fill;
  logic [lgfb_pkg::PIX_W-1:0]        map_pixel;

  modport source (output valid, mode, pixel, row, column, color, use_fill, map_pixel,
                  input ready);
  modport sink (input valid, mode, pixel, row, column, color, use_fill, map_pixel,
                output ready);
endinterface

### hw/rtl/lgfb_rsp_if.sv
// ----------------------------------------------------------------------------
// lgfb_rsp_if
// result channel: valid/ready handshake with one result word
// ----------------------------------------------------------------------------
interface lgfb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lgfb_pkg::COLOR_W-1:0] read_color;
  logic                         ignored;

  modport source (output valid, read_color, ignored, input ready);
  modport sink (input valid, read_color, ignored, output ready);
endinterface

### hw/rtl/lgfb_ctrl.sv
// ----------------------------------------------------------------------------
// lgfb_ctrl
// command sequencer: clearing pass, setup, read/write step loop, result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lgfb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output lgfb_pkg::cmd_t   cmd,
  input  lgfb_pkg::sts_t   sts
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_READ  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.empty ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (sts.last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_DONE: begin
        // result slot frees up when the held word is taken
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LGFB_ASSERT(a_load_into_free_slot, cmd.out_load |-> (!out_valid_r || out_ready), "result overwritten")
  `LGFB_ASSERT(a_accept_goes_setup, (in_valid && in_ready) |=> (state_r == ST_SETUP), "accept lost")
  `LGFB_ASSERT(a_write_after_read, (state_r == ST_WRITE) |-> $past(state_r == ST_READ), "write without read")
  `LGFB_NEVER(a_no_accept_in_clear, in_ready && (state_r == ST_CLEAR), "accept during clear")

endmodule

### hw/rtl/lgfb_datapath.sv
// ----------------------------------------------------------------------------
// lgfb_datapath
// config registers, command decode, walk counters and the three memories
// ----------------------------------------------------------------------------
module lgfb_datapath #(
  parameter int MAX_PIXELS  = lgfb_pkg::MAX_PIXELS_DEF,
  parameter int MAX_ROWS    = lgfb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = lgfb_pkg::MAX_COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lgfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgfb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [lgfb_pkg::MODE_W-1:0]       in_mode,
  input  logic [lgfb_pkg::PIX_W-1:0]        in_pixel,
  input  logic [lgfb_pkg::ROW_W-1:0]        in_row,
  input  logic [lgfb_pkg::COL_W-1:0]        in_column,
  input  logic [lgfb_pkg::COLOR_W-1:0]      in_color,
  input  logic                              in_use_fill,
  input  logic [lgfb_pkg::PIX_W-1:0]        in_map_pixel,
  output logic [lgfb_pkg::COLOR_W-1:0]      out_read_color,
  output logic                              out_ignored,
  input  lgfb_pkg::cmd_t                    cmd,
  output lgfb_pkg::sts_t                    sts
);

  localparam int CELLS   = MAX_ROWS * MAX_COLUMNS;
  localparam int MAX_RC  = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
  localparam int MAX_LEN = (MAX_PIXELS > MAX_RC) ? MAX_PIXELS : MAX_RC;
  localparam int KW      = $clog2(MAX_LEN + 1);
  localparam int LW      = (MAX_RC > 1) ? $clog2(MAX_RC) : 1;
  localparam int PAW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int GAW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CLR_LEN = (MAX_PIXELS > CELLS) ? MAX_PIXELS : CELLS;
  localparam int CLW     = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

  // configuration
  logic [lgfb_pkg::PIX_W-1:0]  pcnt_r;
  logic [lgfb_pkg::RCNT_W-1:0] rcnt_r;
  logic [lgfb_pkg::CCNT_W-1:0] ccnt_r;
  logic [KW-1:0]               np, nr, nc;

  // latched command word
  logic [lgfb_pkg::MODE_W-1:0]  mode_r;
  logic [lgfb_pkg::PIX_W-1:0]   pixel_r;
  logic [lgfb_pkg::ROW_W-1:0]   row_r;
  logic [lgfb_pkg::COL_W-1:0]   col_r;
  logic [lgfb_pkg::COLOR_W-1:0] color_r;
  logic                         fill_r;
  logic [lgfb_pkg::PIX_W-1:0]   mapv_r;

  // decode
  lgfb_pkg::kind_t d_kind;
  logic [KW-1:0]   d_len, d_lines, d_off;
  logic [LW-1:0]   d_line0;
  logic            d_shift, d_rev, d_colmaj, d_ign, d_zero;

  // walk state
  lgfb_pkg::kind_t kind_r;
  logic [KW-1:0]   len_r, k_r, off_r;
  logic [LW-1:0]   line_r, line_last_r;
  logic            shift_r, rev_r, colmaj_r, zero_r, ign_r;
  logic [lgfb_pkg::COLOR_W-1:0] rd_r;

  logic            at_end, move, skip, live;
  logic [KW-1:0]   pos, src;
  logic [GAW-1:0]  dst_cell, src_cell;

  // memories
  logic [lgfb_pkg::COLOR_W-1:0] pix_mem  [MAX_PIXELS];
  logic [lgfb_pkg::COLOR_W-1:0] grid_mem [CELLS];
  logic [lgfb_pkg::PIX_W-1:0]   map_mem  [CELLS];

  logic [lgfb_pkg::COLOR_W-1:0] pix_rd_r, grid_rd_r, pix_wdata, grid_wdata, wdata;
  logic [lgfb_pkg::PIX_W-1:0]   map_rd_r, map_wdata;
  logic [PAW-1:0]               pix_waddr, pix_raddr;
  logic [GAW-1:0]               grid_waddr, map_waddr;
  logic                         pix_we, grid_we, map_we;

  logic [CLW-1:0]               clr_cnt_r;

  logic [lgfb_pkg::COLOR_W-1:0] out_color_r;
  logic                         out_ign_r;

  function automatic logic [GAW-1:0] cell_of(input int r, input int c);
    return GAW'(r * MAX_COLUMNS + c);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= lgfb_pkg::PIXEL_COUNT_RST;
      rcnt_r <= lgfb_pkg::ROW_COUNT_RST;
      ccnt_r <= lgfb_pkg::COLUMN_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgfb_pkg::CFG_PIXEL_COUNT:  pcnt_r <= cfg_data;
        lgfb_pkg::CFG_ROW_COUNT:    rcnt_r <= cfg_data[lgfb_pkg::RCNT_W-1:0];
        lgfb_pkg::CFG_COLUMN_COUNT: ccnt_r <= cfg_data[lgfb_pkg::CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // counts above the build limits act as the limits
  assign np = (int'(pcnt_r) > MAX_PIXELS)  ? KW'(MAX_PIXELS)  : KW'(pcnt_r);
  assign nr = (int'(rcnt_r) > MAX_ROWS)    ? KW'(MAX_ROWS)    : KW'(rcnt_r);
  assign nc = (int'(ccnt_r) > MAX_COLUMNS) ? KW'(MAX_COLUMNS) : KW'(ccnt_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= in_mode;
      pixel_r <= in_pixel;
      row_r   <= in_row;
      col_r   <= in_column;
      color_r <= in_color;
      fill_r  <= in_use_fill;
      mapv_r  <= in_map_pixel;
    end
  end

  // every command becomes lines x len steps; shifts end each line with an edge step
  always_comb begin
    d_kind   = lgfb_pkg::KIND_LIN;
    d_len    = '0;
    d_lines  = '0;
    d_off    = '0;
    d_line0  = '0;
    d_shift  = 1'b0;
    d_rev    = 1'b0;
    d_colmaj = 1'b0;
    d_ign    = 1'b0;
    d_zero   = 1'b0;
    unique case (mode_r) inside
      lgfb_pkg::MODE_WRITE, lgfb_pkg::MODE_READ: begin
        if (mode_r == lgfb_pkg::MODE_READ) d_kind = lgfb_pkg::KIND_READ;
        if (pixel_r < np) begin
          d_len   = KW'(1);
          d_lines = KW'(1);
          d_off   = KW'(pixel_r);
        end else begin
          d_ign = 1'b1;
        end
      end
      lgfb_pkg::MODE_FILL, lgfb_pkg::MODE_CLEAR: begin
        d_len   = np;
        d_lines = KW'(1);
        d_zero  = (mode_r == lgfb_pkg::MODE_CLEAR);
      end
      lgfb_pkg::MODE_SHIFT_R, lgfb_pkg::MODE_SHIFT_L: begin
        d_len   = np;
        d_lines = KW'(1);
        d_shift = 1'b1;
        d_rev   = (mode_r == lgfb_pkg::MODE_SHIFT_R);
      end
      lgfb_pkg::MODE_ROW_COLOR: begin
        d_kind = lgfb_pkg::KIND_GRID;
        if (row_r < nr) begin
          d_len   = nc;
          d_lines = KW'(1);
          d_line0 = LW'(row_r);
        end else begin
          d_ign = 1'b1;
        end
      end
      lgfb_pkg::MODE_COL_COLOR: begin
        d_kind   = lgfb_pkg::KIND_GRID;
        d_colmaj = 1'b1;
        if (col_r < nc) begin
          d_len   = nr;
          d_lines = KW'(1);
          d_line0 = LW'(col_r);
        end else begin
          d_ign = 1'b1;
        end
      end
      lgfb_pkg::MODE_COLS_R, lgfb_pkg::MODE_COLS_L: begin
        d_kind  = lgfb_pkg::KIND_GRID;
        d_len   = nc;
        d_lines = nr;
        d_shift = 1'b1;
        d_rev   = (mode_r == lgfb_pkg::MODE_COLS_R);
      end
      lgfb_pkg::MODE_ROWS_D, lgfb_pkg::MODE_ROWS_U: begin
        d_kind   = lgfb_pkg::KIND_GRID;
        d_colmaj = 1'b1;
        d_len    = nr;
        d_lines  = nc;
        d_shift  = 1'b1;
        d_rev    = (mode_r == lgfb_pkg::MODE_ROWS_D);
      end
      lgfb_pkg::MODE_MAP: begin
        d_kind = lgfb_pkg::KIND_MAP;
        if (row_r < nr && col_r < nc) begin
          d_len   = KW'(1);
          d_lines = KW'(1);
          d_line0 = LW'(row_r);
          d_off   = KW'(col_r);
        end else begin
          d_ign = 1'b1;
        end
      end
      default: d_ign = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      kind_r      <= d_kind;
      len_r       <= d_len;
      k_r         <= '0;
      off_r       <= d_off;
      line_r      <= d_line0;
      line_last_r <= LW'(int'(d_line0) + int'(d_lines) - 1);
      shift_r     <= d_shift;
      rev_r       <= d_rev;
      colmaj_r    <= d_colmaj;
      zero_r      <= d_zero;
      ign_r       <= d_ign;
      rd_r        <= '0;
    end else begin
      if (cmd.advance) begin
        if (at_end) begin
          k_r    <= '0;
          line_r <= line_r + LW'(1);
        end else begin
          k_r <= k_r + KW'(1);
        end
      end
      if (cmd.wr && kind_r == lgfb_pkg::KIND_READ) rd_r <= pix_rd_r;
    end
  end

  assign at_end = (k_r == len_r - KW'(1));
  assign move   = shift_r && !at_end;
  assign skip   = shift_r && at_end && !fill_r;
  assign live   = cmd.wr && !skip;
  assign pos    = (rev_r ? (len_r - KW'(1) - k_r) : k_r) + off_r;
  assign src    = rev_r ? (pos - KW'(1)) : (pos + KW'(1));

  assign dst_cell = colmaj_r ? cell_of(int'(pos), int'(line_r)) : cell_of(int'(line_r), int'(pos));
  assign src_cell = colmaj_r ? cell_of(int'(src), int'(line_r)) : cell_of(int'(line_r), int'(src));

  assign wdata = move ? ((kind_r == lgfb_pkg::KIND_GRID) ? grid_rd_r : pix_rd_r)
                      : (zero_r ? '0 : color_r);

  always_comb begin
    pix_we     = 1'b0;
    pix_waddr  = PAW'(pos);
    pix_wdata  = wdata;
    grid_we    = 1'b0;
    grid_waddr = dst_cell;
    grid_wdata = wdata;
    map_we     = 1'b0;
    map_waddr  = dst_cell;
    map_wdata  = mapv_r;
    if (cmd.clr_step) begin
      pix_we     = (int'(clr_cnt_r) < MAX_PIXELS);
      pix_waddr  = PAW'(clr_cnt_r);
      pix_wdata  = '0;
      grid_we    = (int'(clr_cnt_r) < CELLS);
      grid_waddr = GAW'(clr_cnt_r);
      grid_wdata = '0;
      map_we     = (int'(clr_cnt_r) < CELLS);
      map_waddr  = GAW'(clr_cnt_r);
      map_wdata  = lgfb_pkg::NO_PIXEL;
    end else begin
      case (kind_r)
        lgfb_pkg::KIND_LIN: pix_we = live;
        lgfb_pkg::KIND_GRID: begin
          // grid cell write also lands on the mapped pixel when it is in use
          grid_we   = live;
          pix_we    = live && (map_rd_r < np);
          pix_waddr = PAW'(map_rd_r);
        end
        lgfb_pkg::KIND_MAP: map_we = live;
        default: ;
      endcase
    end
  end

  assign pix_raddr = (kind_r == lgfb_pkg::KIND_READ) ? PAW'(pos) : PAW'(src);

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
    if (cmd.rd) pix_rd_r <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (cmd.rd) grid_rd_r <= grid_mem[src_cell];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.rd) map_rd_r <= map_mem[dst_cell];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + CLW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_color_r <= rd_r;
      out_ign_r   <= ign_r;
    end
  end

  assign out_read_color = out_color_r;
  assign out_ignored    = out_ign_r;

  assign sts.clr_done = (clr_cnt_r == CLW'(CLR_LEN - 1));
  assign sts.empty    = (d_len == '0) || (d_lines == '0);
  assign sts.last     = at_end && (line_r == line_last_r);

endmodule

### hw/rtl/led_grid_frame_buffer_engine.sv
// ----------------------------------------------------------------------------
// led_grid_frame_buffer_engine
// command-driven led frame buffer with a logical grid and a grid-to-pixel map
// ----------------------------------------------------------------------------
// channel   dir  handshake     word
// in_cmd    in   valid/ready   mode, pixel, row, column, color, use_fill, map_pixel
// out_rsp   out  valid/ready   read_color, ignored
// cfg_*     in   write enable  cfg_index, cfg_data
//
// one command at a time: a setup step, then for each touched entry a registered
// memory read followed by the write, then a hand-off step
// after reset a clearing pass sweeps max(MAX_PIXELS, MAX_ROWS*MAX_COLUMNS) addresses
// (1024 by default) and no command is taken until it ends
// a finished result waits in the output register; the next command is taken
// meanwhile and stalls only at its own hand-off if the result is still unread
// ----------------------------------------------------------------------------
module led_grid_frame_buffer_engine #(
  parameter int MAX_PIXELS  = lgfb_pkg::MAX_PIXELS_DEF,
  parameter int MAX_ROWS    = lgfb_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = lgfb_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lgfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgfb_pkg::CFG_DATA_W-1:0] cfg_data,
  lgfb_cmd_if.sink                        in_cmd,
  lgfb_rsp_if.source                      out_rsp
);

  lgfb_pkg::cmd_t cmd;
  lgfb_pkg::sts_t sts;

  lgfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_cmd.valid),
    .in_ready  (in_cmd.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lgfb_datapath #(
    .MAX_PIXELS  (MAX_PIXELS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mode        (in_cmd.mode),
    .in_pixel       (in_cmd.pixel),
    .in_row         (in_cmd.row),
    .in_column      (in_cmd.column),
    .in_color       (in_cmd.color),
    .in_use_fill    (in_cmd.use_fill),
    .in_map_pixel   (in_cmd.map_pixel),
    .out_read_color (out_rsp.read_color),
    .out_ignored    (out_rsp.ignored),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
